// ----- sv/jsu_pkg.sv -----
// shared types and constants for the json string unescaper
`timescale 1ns / 1ps

package jsu_pkg;

	// most results one input byte can cause (four utf-8 bytes)
	localparam int MAX_RES = 4;
	localparam int RES_IDX_W = $clog2(MAX_RES);
	localparam int RES_CNT_W = $clog2(MAX_RES + 1);

	// result queue
	localparam int QDEPTH = 8;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_CLOSE = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ERR_NONE         = 4'd0,
		ERR_UNTERMINATED = 4'd1,
		ERR_CONTROL_CHAR = 4'd2,
		ERR_OPEN_ESCAPE  = 4'd3,
		ERR_BAD_ESCAPE   = 4'd4,
		ERR_SHORT_U      = 4'd5,
		ERR_BAD_HEX      = 4'd6,
		ERR_NO_LOW       = 4'd7,
		ERR_BAD_LOW      = 4'd8,
		ERR_LONE_LOW     = 4'd9,
		ERR_NO_OPEN      = 4'd10
	} err_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		err_t       err;
		logic       last;
	} res_t;

endpackage

// ----- sv/jsu_decode.sv -----
// escape decoder: parse state and the results caused by one input byte
`timescale 1ns / 1ps

module jsu_decode (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      take,
	input  logic [7:0]                                in_byte,
	input  logic                                      text_end,
	output logic [jsu_pkg::RES_CNT_W-1:0]             res_n,
	output jsu_pkg::res_t [jsu_pkg::MAX_RES-1:0]      res
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_STR,
		PH_ESC,
		PH_HEX1,
		PH_BSL,
		PH_U,
		PH_HEX2
	} phase_t;

	typedef struct packed {
		logic [jsu_pkg::RES_CNT_W-1:0] cnt;
		logic [3:0][7:0]               b;
	} utf8_t;

	phase_t      phase_q, phase_d;
	logic [1:0]  hex_cnt_q, hex_cnt_d;
	logic [15:0] acc_q, acc_d;
	logic [9:0]  high_q, high_d;

	logic                          fail;
	jsu_pkg::err_t                 fail_code;
	logic                          hex_ok;
	logic [3:0]                    hex_val;
	logic [15:0]                   acc_new;
	logic [20:0]                   cp;
	utf8_t                         enc;
	logic                          do_enc;
	logic                          one_byte;
	logic [7:0]                    one_val;
	logic                          close;

	function automatic utf8_t utf8_encode(input logic [20:0] c);
		utf8_t u;
		u = '0;
		if (c <= 21'h7F) begin
			u.cnt  = jsu_pkg::RES_CNT_W'(1);
			u.b[0] = c[7:0];
		end else if (c <= 21'h7FF) begin
			u.cnt  = jsu_pkg::RES_CNT_W'(2);
			u.b[0] = {3'b110, c[10:6]};
			u.b[1] = {2'b10, c[5:0]};
		end else if (c <= 21'hFFFF) begin
			u.cnt  = jsu_pkg::RES_CNT_W'(3);
			u.b[0] = {4'b1110, c[15:12]};
			u.b[1] = {2'b10, c[11:6]};
			u.b[2] = {2'b10, c[5:0]};
		end else begin
			u.cnt  = jsu_pkg::RES_CNT_W'(4);
			u.b[0] = {5'b11110, c[20:18]};
			u.b[1] = {2'b10, c[17:12]};
			u.b[2] = {2'b10, c[11:6]};
			u.b[3] = {2'b10, c[5:0]};
		end
		return u;
	endfunction

	// hex digit value
	always_comb begin
		hex_ok  = 1'b1;
		hex_val = '0;
		case (in_byte) inside
			[8'h30:8'h39]: hex_val = 4'(in_byte - 8'h30);
			[8'h61:8'h66]: hex_val = 4'(in_byte - 8'h57);
			[8'h41:8'h46]: hex_val = 4'(in_byte - 8'h37);
			default:       hex_ok  = 1'b0;
		endcase
	end

	assign acc_new = {acc_q[11:0], hex_val};

	// second unit of a pair: 0x10000 + (high << 10) + (low - 0xdc00)
	assign cp = (phase_q == PH_HEX1) ? {5'd0, acc_new}
	                                 : {11'({1'b0, high_q} + 11'h40), acc_new[9:0]};
	assign enc = utf8_encode(cp);

	always_comb begin
		phase_d   = phase_q;
		hex_cnt_d = hex_cnt_q;
		acc_d     = acc_q;
		high_d    = high_q;
		fail      = 1'b0;
		fail_code = jsu_pkg::ERR_NONE;
		do_enc    = 1'b0;
		one_byte  = 1'b0;
		one_val   = '0;
		close     = 1'b0;
		if (text_end) begin
			phase_d   = PH_IDLE;
			hex_cnt_d = '0;
			acc_d     = '0;
			high_d    = '0;
			unique case (phase_q)
				PH_STR: begin
					fail      = 1'b1;
					fail_code = jsu_pkg::ERR_UNTERMINATED;
				end
				PH_ESC: begin
					fail      = 1'b1;
					fail_code = jsu_pkg::ERR_OPEN_ESCAPE;
				end
				PH_HEX1, PH_HEX2: begin
					fail      = 1'b1;
					fail_code = jsu_pkg::ERR_SHORT_U;
				end
				PH_BSL, PH_U: begin
					fail      = 1'b1;
					fail_code = jsu_pkg::ERR_NO_LOW;
				end
				default: begin
				end
			endcase
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (in_byte != 8'h22) begin
						fail      = 1'b1;
						fail_code = jsu_pkg::ERR_NO_OPEN;
					end else begin
						phase_d = PH_STR;
					end
				end
				PH_STR: begin
					if (in_byte < 8'h20) begin
						fail      = 1'b1;
						fail_code = jsu_pkg::ERR_CONTROL_CHAR;
					end else if (in_byte == 8'h22) begin
						phase_d = PH_IDLE;
						close   = 1'b1;
					end else if (in_byte == 8'h5C) begin
						phase_d = PH_ESC;
					end else begin
						one_byte = 1'b1;
						one_val  = in_byte;
					end
				end
				PH_ESC: begin
					phase_d  = PH_STR;
					one_byte = 1'b1;
					case (in_byte)
						8'h22:   one_val = 8'h22;
						8'h5C:   one_val = 8'h5C;
						8'h2F:   one_val = 8'h2F;
						8'h62:   one_val = 8'h08;
						8'h66:   one_val = 8'h0C;
						8'h6E:   one_val = 8'h0A;
						8'h72:   one_val = 8'h0D;
						8'h74:   one_val = 8'h09;
						8'h75: begin
							one_byte  = 1'b0;
							phase_d   = PH_HEX1;
							hex_cnt_d = '0;
							acc_d     = '0;
						end
						default: begin
							one_byte  = 1'b0;
							fail      = 1'b1;
							fail_code = jsu_pkg::ERR_BAD_ESCAPE;
						end
					endcase
				end
				PH_HEX1, PH_HEX2: begin
					if (!hex_ok) begin
						fail      = 1'b1;
						fail_code = jsu_pkg::ERR_BAD_HEX;
					end else if (hex_cnt_q != 2'd3) begin
						hex_cnt_d = hex_cnt_q + 2'd1;
						acc_d     = acc_new;
					end else begin
						hex_cnt_d = '0;
						acc_d     = acc_new;
						if (phase_q == PH_HEX1) begin
							if (acc_new >= 16'hD800 && acc_new <= 16'hDBFF) begin
								high_d  = acc_new[9:0];
								phase_d = PH_BSL;
							end else if (acc_new >= 16'hDC00 && acc_new <= 16'hDFFF) begin
								fail      = 1'b1;
								fail_code = jsu_pkg::ERR_LONE_LOW;
							end else begin
								phase_d = PH_STR;
								acc_d   = '0;
								do_enc  = 1'b1;
							end
						end else begin
							if (acc_new < 16'hDC00 || acc_new > 16'hDFFF) begin
								fail      = 1'b1;
								fail_code = jsu_pkg::ERR_BAD_LOW;
							end else begin
								phase_d = PH_STR;
								acc_d   = '0;
								high_d  = '0;
								do_enc  = 1'b1;
							end
						end
					end
				end
				PH_BSL: begin
					if (in_byte != 8'h5C) begin
						fail      = 1'b1;
						fail_code = jsu_pkg::ERR_NO_LOW;
					end else begin
						phase_d = PH_U;
					end
				end
				PH_U: begin
					if (in_byte != 8'h75) begin
						fail      = 1'b1;
						fail_code = jsu_pkg::ERR_NO_LOW;
					end else begin
						phase_d   = PH_HEX2;
						hex_cnt_d = '0;
						acc_d     = '0;
					end
				end
				default: begin
					phase_d   = PH_IDLE;
					hex_cnt_d = '0;
					acc_d     = '0;
					high_d    = '0;
				end
			endcase
		end
		if (fail) begin
			phase_d   = PH_IDLE;
			hex_cnt_d = '0;
			acc_d     = '0;
			high_d    = '0;
		end
	end

	// result slots for this byte
	always_comb begin
		res_n = '0;
		res   = '0;
		if (fail) begin
			res_n       = jsu_pkg::RES_CNT_W'(1);
			res[0].kind = jsu_pkg::KIND_ERROR;
			res[0].err  = fail_code;
			res[0].last = 1'b1;
		end else if (close) begin
			res_n       = jsu_pkg::RES_CNT_W'(1);
			res[0].kind = jsu_pkg::KIND_CLOSE;
			res[0].err  = jsu_pkg::ERR_NONE;
			res[0].last = 1'b1;
		end else if (one_byte) begin
			res_n       = jsu_pkg::RES_CNT_W'(1);
			res[0].kind = jsu_pkg::KIND_BYTE;
			res[0].data = one_val;
			res[0].err  = jsu_pkg::ERR_NONE;
			res[0].last = 1'b1;
		end else if (do_enc) begin
			res_n = enc.cnt;
			for (int i = 0; i < jsu_pkg::MAX_RES; i++) begin
				res[i].kind = jsu_pkg::KIND_BYTE;
				res[i].data = enc.b[i];
				res[i].err  = jsu_pkg::ERR_NONE;
				res[i].last = (jsu_pkg::RES_CNT_W'(i + 1) == enc.cnt);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			hex_cnt_q <= '0;
			acc_q     <= '0;
			high_q    <= '0;
		end else if (take) begin
			phase_q   <= phase_d;
			hex_cnt_q <= hex_cnt_d;
			acc_q     <= acc_d;
			high_q    <= high_d;
		end
	end

	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(res_n != '0 && res[0].kind == jsu_pkg::KIND_ERROR) |-> res_n == jsu_pkg::RES_CNT_W'(1))
		else $error("error result not alone");

	a_fail_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(take && fail) |=> phase_q == PH_IDLE && hex_cnt_q == '0)
		else $error("parser not idle after error");

	a_hex_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(hex_cnt_q != '0) |-> (phase_q == PH_HEX1 || phase_q == PH_HEX2))
		else $error("hex count outside a unicode escape");

endmodule

// ----- sv/jsu_queue.sv -----
// result queue: takes up to four results per cycle, gives one per cycle when popped
`timescale 1ns / 1ps

module jsu_queue (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [jsu_pkg::RES_CNT_W-1:0]        push_n,
	input  jsu_pkg::res_t [jsu_pkg::MAX_RES-1:0] push_data,
	input  logic                                 pop,
	output logic                                 head_valid,
	output jsu_pkg::res_t                        head,
	output logic                                 room
);

	jsu_pkg::res_t                   mem_q [jsu_pkg::QDEPTH];
	logic [jsu_pkg::QPTR_W-1:0]      wr_q, rd_q;
	logic [jsu_pkg::QCNT_W-1:0]      cnt_q;
	logic [jsu_pkg::QDEPTH-1:0]      wen;
	logic [jsu_pkg::QPTR_W-1:0]      woff [jsu_pkg::QDEPTH];

	// slot s takes result (s - wr) when that offset is below the push count
	always_comb begin
		for (int s = 0; s < jsu_pkg::QDEPTH; s++) begin
			woff[s] = jsu_pkg::QPTR_W'(s) - wr_q;
			wen[s]  = (jsu_pkg::QCNT_W'(woff[s]) < jsu_pkg::QCNT_W'(push_n));
		end
	end

	always_ff @(posedge clk) begin
		for (int s = 0; s < jsu_pkg::QDEPTH; s++) begin
			if (wen[s]) begin
				mem_q[s] <= push_data[woff[s][jsu_pkg::RES_IDX_W-1:0]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + jsu_pkg::QPTR_W'(push_n);
			rd_q  <= rd_q + jsu_pkg::QPTR_W'(pop);
			cnt_q <= cnt_q + jsu_pkg::QCNT_W'(push_n) - jsu_pkg::QCNT_W'(pop);
		end
	end

	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];
	assign room       = (cnt_q <= jsu_pkg::QCNT_W'(jsu_pkg::QDEPTH - jsu_pkg::MAX_RES));

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= jsu_pkg::QCNT_W'(jsu_pkg::QDEPTH))
		else $error("result queue overflow");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> cnt_q == jsu_pkg::QCNT_W'($past(cnt_q)
			+ jsu_pkg::QCNT_W'($past(push_n)) - jsu_pkg::QCNT_W'($past(pop))))
		else $error("queue count lost track");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		jsu_pkg::QPTR_W'(wr_q - rd_q) == jsu_pkg::QPTR_W'(cnt_q))
		else $error("queue pointers disagree with count");

endmodule

// ----- sv/json_string_unescape.sv -----
// top level of the json string literal unescaper
`timescale 1ns / 1ps
//
// Input channel (in_valid / in_stall) carries one raw byte of JSON text per
// transaction, or a text_end marker with no byte. Output channel (out_valid /
// out_stall) carries one result per transaction: a decoded byte, a string
// closed marker, or a numbered error; last flags the final result caused by
// one input transaction. One input transaction causes zero to four results.
// An input byte is decoded in the cycle it is accepted and its results are
// written into an eight-entry result queue; the first of them reaches the
// output behind earlier ones. The block takes one input transaction per
// cycle as long as the queue has room for four more results, so the rate is
// set by the queue depth against the output drain of one result per cycle:
// a multi-byte utf-8 burst needs at least six input bytes, which the queue
// absorbs without stalling when the receiver keeps up.
// When the receiver stalls, results stay in the queue, and in_stall rises
// once fewer than four entries are free. Reset empties the queue and puts
// the parser in idle, waiting for an opening quote.
//
module json_string_unescape (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       text_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic [3:0] error_code,
	output logic       last
);

	logic                                 take;
	logic                                 pop;
	logic                                 room;
	logic [jsu_pkg::RES_CNT_W-1:0]        dec_n;
	logic [jsu_pkg::RES_CNT_W-1:0]        push_n;
	jsu_pkg::res_t [jsu_pkg::MAX_RES-1:0] dec_res;
	jsu_pkg::res_t                        head;

	assign in_stall = !room;
	assign take     = in_valid && room;
	assign push_n   = take ? dec_n : '0;
	assign pop      = out_valid && !out_stall;

	jsu_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.in_byte  (in_byte),
		.text_end (text_end),
		.res_n    (dec_n),
		.res      (dec_res)
	);

	jsu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (push_n),
		.push_data  (dec_res),
		.pop        (pop),
		.head_valid (out_valid),
		.head       (head),
		.room       (room)
	);

	assign kind       = head.kind;
	assign out_byte   = head.data;
	assign error_code = head.err;
	assign last       = head.last;

endmodule

// ----- tb/sv/json_string_unescape_test.sv -----
// testbench for the json string literal unescaper
`timescale 1ns / 1ps

module json_string_unescape_test;

	localparam int RANDOM_ITEMS = 280;
	localparam int CALM_ITEMS = 40;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 20;

	localparam logic [7:0] QUOTE = 8'h22;
	localparam logic [7:0] BACKSLASH = 8'h5C;

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_STR,
		SCAN_ESC,
		SCAN_HEX,
		SCAN_WAIT_BSL,
		SCAN_WAIT_U,
		SCAN_HEX_LOW
	} scan_t;

	typedef struct {
		logic [7:0] b;
		logic       fin;
	} text_item_t;

	class unescape_scoreboard;
		scan_t         scan = SCAN_IDLE;
		logic [1:0]    hex_cnt = '0;
		logic [15:0]   accum = '0;
		logic [9:0]    high_bits = '0;
		jsu_pkg::res_t decoded_q[$];
		int            inputs_taken = 0;
		int            results_checked = 0;
		int            closes = 0;
		int            flagged_errors = 0;
		int            mismatches = 0;

		function void clear_scan();
			scan = SCAN_IDLE;
			hex_cnt = '0;
			accum = '0;
			high_bits = '0;
		endfunction

		function void add_result(jsu_pkg::res_t r);
			decoded_q.insert(decoded_q.size(), r);
		endfunction

		function void push_byte(logic [7:0] b, logic l);
			add_result('{kind: jsu_pkg::KIND_BYTE, data: b, err: jsu_pkg::ERR_NONE, last: l});
		endfunction

		function void flag(jsu_pkg::err_t e);
			clear_scan();
			add_result('{kind: jsu_pkg::KIND_ERROR, data: 8'h00, err: e, last: 1'b1});
		endfunction

		function void push_utf8(logic [20:0] cp);
			if (cp <= 21'h7F) begin
				push_byte(cp[7:0], 1'b1);
			end else if (cp <= 21'h7FF) begin
				push_byte({3'b110, cp[10:6]}, 1'b0);
				push_byte({2'b10, cp[5:0]}, 1'b1);
			end else if (cp <= 21'hFFFF) begin
				push_byte({4'b1110, cp[15:12]}, 1'b0);
				push_byte({2'b10, cp[11:6]}, 1'b0);
				push_byte({2'b10, cp[5:0]}, 1'b1);
			end else begin
				push_byte({5'b11110, cp[20:18]}, 1'b0);
				push_byte({2'b10, cp[17:12]}, 1'b0);
				push_byte({2'b10, cp[11:6]}, 1'b0);
				push_byte({2'b10, cp[5:0]}, 1'b1);
			end
		endfunction

		function int hex_value(logic [7:0] c);
			if (c >= "0" && c <= "9")
				return int'(c - 8'h30);
			if (c >= "a" && c <= "f")
				return int'(c - 8'h57);
			if (c >= "A" && c <= "F")
				return int'(c - 8'h37);
			return -1;
		endfunction

		// predict the results of one accepted input transaction
		function void take_text(logic [7:0] c, logic fin);
			int d;
			logic [15:0] unit;
			inputs_taken++;
			if (fin) begin
				case (scan)
					SCAN_STR: flag(jsu_pkg::ERR_UNTERMINATED);
					SCAN_ESC: flag(jsu_pkg::ERR_OPEN_ESCAPE);
					SCAN_HEX, SCAN_HEX_LOW: flag(jsu_pkg::ERR_SHORT_U);
					SCAN_WAIT_BSL, SCAN_WAIT_U: flag(jsu_pkg::ERR_NO_LOW);
					default: clear_scan();
				endcase
				return;
			end
			case (scan)
				SCAN_IDLE: begin
					if (c != QUOTE)
						flag(jsu_pkg::ERR_NO_OPEN);
					else
						scan = SCAN_STR;
				end
				SCAN_STR: begin
					if (c < 8'h20) begin
						flag(jsu_pkg::ERR_CONTROL_CHAR);
					end else if (c == QUOTE) begin
						scan = SCAN_IDLE;
						add_result('{kind: jsu_pkg::KIND_CLOSE, data: 8'h00,
							err: jsu_pkg::ERR_NONE, last: 1'b1});
					end else if (c == BACKSLASH) begin
						scan = SCAN_ESC;
					end else begin
						push_byte(c, 1'b1);
					end
				end
				SCAN_ESC: begin
					scan = SCAN_STR;
					case (c)
						QUOTE: push_byte(8'h22, 1'b1);
						BACKSLASH: push_byte(8'h5C, 1'b1);
						"/": push_byte(8'h2F, 1'b1);
						"b": push_byte(8'h08, 1'b1);
						"f": push_byte(8'h0C, 1'b1);
						"n": push_byte(8'h0A, 1'b1);
						"r": push_byte(8'h0D, 1'b1);
						"t": push_byte(8'h09, 1'b1);
						"u": begin
							scan = SCAN_HEX;
							hex_cnt = '0;
							accum = '0;
						end
						default: flag(jsu_pkg::ERR_BAD_ESCAPE);
					endcase
				end
				SCAN_HEX, SCAN_HEX_LOW: begin
					d = hex_value(c);
					if (d < 0) begin
						flag(jsu_pkg::ERR_BAD_HEX);
					end else begin
						accum = {accum[11:0], d[3:0]};
						if (hex_cnt != 2'd3) begin
							hex_cnt++;
						end else begin
							hex_cnt = '0;
							unit = accum;
							if (scan == SCAN_HEX) begin
								if (unit >= 16'hD800 && unit <= 16'hDBFF) begin
									high_bits = unit[9:0];
									scan = SCAN_WAIT_BSL;
								end else if (unit >= 16'hDC00 && unit <= 16'hDFFF) begin
									flag(jsu_pkg::ERR_LONE_LOW);
								end else begin
									scan = SCAN_STR;
									accum = '0;
									push_utf8({5'd0, unit});
								end
							end else if (unit < 16'hDC00 || unit > 16'hDFFF) begin
								flag(jsu_pkg::ERR_BAD_LOW);
							end else begin
								scan = SCAN_STR;
								accum = '0;
								push_utf8(21'h10000 + {high_bits, unit[9:0]});
								high_bits = '0;
							end
						end
					end
				end
				SCAN_WAIT_BSL: begin
					if (c != BACKSLASH)
						flag(jsu_pkg::ERR_NO_LOW);
					else
						scan = SCAN_WAIT_U;
				end
				SCAN_WAIT_U: begin
					if (c != "u") begin
						flag(jsu_pkg::ERR_NO_LOW);
					end else begin
						scan = SCAN_HEX_LOW;
						hex_cnt = '0;
						accum = '0;
					end
				end
				default: clear_scan();
			endcase
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $time, what);
			mismatches++;
		endtask

		task check_result(logic [1:0] k, logic [7:0] b, logic [3:0] e, logic l);
			jsu_pkg::res_t want;
			results_checked++;
			if (decoded_q.size() == 0) begin
				report($sformatf("unexpected result kind %0d byte %02h code %0d last %0d",
					k, b, e, l));
				return;
			end
			want = decoded_q.pop_front();
			if (k !== want.kind || b !== want.data || e !== want.err || l !== want.last)
				report($sformatf("got kind %0d byte %02h code %0d last %0d, want %0d %02h %0d %0d",
					k, b, e, l, want.kind, want.data, want.err, want.last));
			if (want.kind == jsu_pkg::KIND_CLOSE)
				closes++;
			if (want.kind == jsu_pkg::KIND_ERROR)
				flagged_errors++;
		endtask

		function int pending();
			return decoded_q.size();
		endfunction

		task check_drained();
			if (decoded_q.size() != 0)
				report($sformatf("%0d expected results never came", decoded_q.size()));
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       text_end;
	logic       out_valid;
	logic       out_stall;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic [3:0] error_code;
	logic       last;

	unescape_scoreboard sb = new;
	text_item_t text_q[$];
	logic calm = 1'b0;
	bit   stall_on = 1'b1;
	int   stall_left = 0;
	int   rx_cycles = 0;
	int   quiet_cycles = 0;

	json_string_unescape dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.text_end   (text_end),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.out_byte   (out_byte),
		.error_code (error_code),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void add_text(logic [7:0] b, logic fin);
		text_item_t it;
		it.b = b;
		it.fin = fin;
		text_q.insert(text_q.size(), it);
	endfunction

	function automatic void put_byte(logic [7:0] b);
		add_text(b, 1'b0);
	endfunction

	// the byte under an end marker is ignored, so it carries noise
	function automatic void put_end();
		add_text(8'($urandom_range(0, 255)), 1'b1);
	endfunction

	function automatic logic [7:0] hex_char(int v);
		if (v < 10)
			return 8'(8'h30 + v);
		return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 10);
	endfunction

	function automatic void put_hex(logic [15:0] code, int n);
		for (int i = 0; i < n; i++)
			put_byte(hex_char((code >> (12 - 4 * i)) & 15));
	endfunction

	function automatic void put_u(logic [15:0] code);
		put_byte(BACKSLASH);
		put_byte("u");
		put_hex(code, 4);
	endfunction

	function automatic logic [15:0] pick_span(logic [15:0] lo, logic [15:0] hi);
		case ($urandom_range(0, 3))
			0: return lo;
			1: return hi;
			default: return 16'($urandom_range(lo, hi));
		endcase
	endfunction

	function automatic logic [15:0] pick_bmp();
		logic [15:0] code;
		case ($urandom_range(0, 5))
			0: return pick_span(16'h0000, 16'h007F);
			1: return pick_span(16'h0080, 16'h07FF);
			2: return pick_span(16'h0800, 16'hD7FF);
			3: return pick_span(16'hE000, 16'hFFFF);
			default: begin
				do
					code = 16'($urandom_range(0, 16'hFFFF));
				while (code >= 16'hD800 && code <= 16'hDFFF);
				return code;
			end
		endcase
	endfunction

	function automatic logic [7:0] pick_non_hex();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"));
		return c;
	endfunction

	function automatic logic [7:0] pick_bad_escape();
		logic [7:0] c;
		bool_loop: do
			c = 8'($urandom_range(0, 255));
		while (c == QUOTE || c == BACKSLASH || c == "/" || c == "b" || c == "f" ||
			c == "n" || c == "r" || c == "t" || c == "u");
		return c;
	endfunction

	function automatic logic [7:0] pick_plain();
		logic [7:0] c;
		do
			c = 8'($urandom_range(8'h20, 8'hFF));
		while (c == QUOTE || c == BACKSLASH);
		return c;
	endfunction

	function automatic void put_high();
		put_u(pick_span(16'hD800, 16'hDBFF));
	endfunction

	// cut a string short in one of the ways the decoder must flag
	function automatic void put_break();
		logic [15:0] code;
		case ($urandom_range(1, 12))
			1: put_end();
			2: put_byte(8'($urandom_range(0, 8'h1F)));
			3: begin
				put_byte(BACKSLASH);
				put_end();
			end
			4: begin
				put_byte(BACKSLASH);
				put_byte(pick_bad_escape());
			end
			5: begin
				put_byte(BACKSLASH);
				put_byte("u");
				put_hex(pick_bmp(), $urandom_range(0, 3));
				put_end();
			end
			6: begin
				put_byte(BACKSLASH);
				put_byte("u");
				put_hex(pick_bmp(), $urandom_range(0, 3));
				put_byte(pick_non_hex());
			end
			7: begin
				put_high();
				if ($urandom_range(0, 2) == 0)
					put_end();
				else begin
					do
						code[7:0] = 8'($urandom_range(0, 255));
					while (code[7:0] == BACKSLASH);
					put_byte(code[7:0]);
				end
			end
			8: begin
				put_high();
				put_byte(BACKSLASH);
				if ($urandom_range(0, 2) == 0)
					put_end();
				else begin
					do
						code[7:0] = 8'($urandom_range(0, 255));
					while (code[7:0] == "u");
					put_byte(code[7:0]);
				end
			end
			9: begin
				put_high();
				put_byte(BACKSLASH);
				put_byte("u");
				put_hex(pick_span(16'hDC00, 16'hDFFF), $urandom_range(0, 3));
				put_end();
			end
			10: begin
				put_high();
				put_byte(BACKSLASH);
				put_byte("u");
				put_hex(pick_span(16'hDC00, 16'hDFFF), $urandom_range(0, 3));
				put_byte(pick_non_hex());
			end
			11: begin
				put_high();
				do
					code = 16'($urandom_range(0, 16'hFFFF));
				while (code >= 16'hDC00 && code <= 16'hDFFF);
				put_u(code);
			end
			default: put_u(pick_span(16'hDC00, 16'hDFFF));
		endcase
	endfunction

	// one string literal with random content, mostly well formed
	function automatic void put_string();
		int segs;
		logic [7:0] esc_set [8] = '{QUOTE, BACKSLASH, "/", "b", "f", "n", "r", "t"};
		put_byte(QUOTE);
		segs = $urandom_range(0, 5);
		for (int i = 0; i < segs; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 9: put_byte(pick_plain());
				3, 4: begin
					put_byte(BACKSLASH);
					put_byte(esc_set[$urandom_range(0, 7)]);
				end
				5, 6: put_u(pick_bmp());
				default: begin
					put_high();
					put_u(pick_span(16'hDC00, 16'hDFFF));
				end
			endcase
		end
		if ($urandom_range(0, 3) == 0)
			put_break();
		else
			put_byte(QUOTE);
	endfunction

	// noise between strings: an end marker or a stray byte while idle
	function automatic void put_noise();
		logic [7:0] c;
		if ($urandom_range(0, 1) == 0) begin
			put_end();
		end else begin
			do
				c = 8'($urandom_range(0, 255));
			while (c == QUOTE);
			put_byte(c);
		end
	endfunction

	task send_text(text_item_t it);
		in_valid <= 1'b1;
		in_byte <= it.b;
		text_end <= it.fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.take_text(it.b, it.fin);
	endtask

	task hold_off(int n);
		in_valid <= 1'b0;
		in_byte <= 8'($urandom_range(0, 255));
		repeat (n) @(posedge clk);
	endtask

	initial begin
		int n_total;
		bit gaps_on;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		text_end = 1'b0;
		gaps_on = 1'b1;

		// directed: idle cases, extremes of plain bytes, max code point, \u0000, control char
		put_end();
		put_byte(8'h00);
		put_byte(QUOTE);
		put_byte(8'h20);
		put_byte(8'hFF);
		put_byte(BACKSLASH);
		put_byte("n");
		put_u(16'hDBFF);
		put_u(16'hDFFF);
		put_byte(QUOTE);
		put_byte(QUOTE);
		put_u(16'h0000);
		put_byte(8'h1F);
		n_total = RANDOM_ITEMS;
		while (text_q.size() < n_total) begin
			if ($urandom_range(0, 9) == 0)
				put_noise();
			else
				put_string();
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < text_q.size(); i++) begin
			if (i % 24 == 0)
				gaps_on = $urandom_range(0, 3) != 0;
			if (i == text_q.size() - CALM_ITEMS)
				calm <= 1'b1;
			if (i < text_q.size() - CALM_ITEMS && gaps_on && $urandom_range(0, 3) == 0)
				hold_off($urandom_range(1, 16));
			send_text(text_q[i]);
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		sb.check_drained();
		$display("fed %0d text transactions, checked %0d results", sb.inputs_taken,
			sb.results_checked);
		$display("%0d strings closed, %0d errors flagged, %0d mismatches", sb.closes,
			sb.flagged_errors, sb.mismatches);
		if (sb.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// receiver: check each result, stall in random bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(kind, out_byte, error_code, last);
			rx_cycles++;
			if (rx_cycles % 256 == 0)
				stall_on = $urandom_range(0, 2) != 0;
			if (calm || !stall_on) begin
				out_stall <= 1'b0;
				stall_left = 0;
			end else if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 5) == 0)
					stall_left = $urandom_range(1, 16);
			end
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no transaction for %0d cycles", QUIET_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

endmodule
